// ----- rtl/nsag_pkg.sv -----
// ----------------------------------------------------------------------------
// nsag_pkg
// Shared widths and codes of the strided address generator.
// ----------------------------------------------------------------------------
package nsag_pkg;

	localparam int EXTENT_W   = 16;
	localparam int STRIDE_W   = 32;
	localparam int CFG_DATA_W = 32;

	typedef enum logic {
		FUNC_START   = 1'b0,
		FUNC_ADVANCE = 1'b1
	} func_t;

endpackage

// ----- rtl/nsag_ifs.sv -----
// ----------------------------------------------------------------------------
// nsag_cmd_if / nsag_res_if
// Valid/ready channels of the strided address generator.
// ----------------------------------------------------------------------------
interface nsag_cmd_if #(
	parameter int ADDR_BITS = 48
) ();
	logic                 valid;
	logic                 ready;
	nsag_pkg::func_t      func;
	logic [ADDR_BITS-1:0] base_address;

	modport source (output valid, func, base_address, input ready);
	modport sink   (input valid, func, base_address, output ready);
endinterface

interface nsag_res_if #(
	parameter int ADDR_BITS = 48
) ();
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] address;
	logic                 valid_res;

	modport source (output valid, address, valid_res, input ready);
	modport sink   (input valid, address, valid_res, output ready);
endinterface

// ----- rtl/nsag_cfg.sv -----
// ----------------------------------------------------------------------------
// nsag_cfg
// Extent and stride registers, with a short pipeline that derives the
// per-dimension step added when that dimension is the one that increments.
// ----------------------------------------------------------------------------
module nsag_cfg #(
	parameter int NUM_DIMS  = 4,
	parameter int ADDR_BITS = 48,
	parameter int IDX_W     = 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [IDX_W-1:0]                      cfg_index,
	input  logic [nsag_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	output logic [nsag_pkg::EXTENT_W-1:0]         em1 [NUM_DIMS],
	output logic [ADDR_BITS-1:0]                  step [NUM_DIMS],
	output logic                                  settled
);

	localparam int PROD_W   = nsag_pkg::EXTENT_W + nsag_pkg::STRIDE_W + 1;
	localparam int SETTLE_W = $clog2(NUM_DIMS + 2);

	logic [nsag_pkg::EXTENT_W-1:0]        extent_q [NUM_DIMS];
	logic signed [nsag_pkg::STRIDE_W-1:0] stride_q [NUM_DIMS];
	logic signed [PROD_W-1:0]             prod     [NUM_DIMS];
	logic [ADDR_BITS-1:0]                 rewind_q [NUM_DIMS];
	logic [ADDR_BITS-1:0]                 suffix_q [NUM_DIMS];
	logic [ADDR_BITS-1:0]                 step_q   [NUM_DIMS];
	logic [SETTLE_W-1:0]                  settle_q;

	for (genvar d = 0; d < NUM_DIMS; d++) begin : g_dim
		// zero extent acts as one
		assign em1[d]  = (extent_q[d] == '0) ? '0 : extent_q[d] - 1'b1;
		assign prod[d] = $signed({1'b0, em1[d]}) * stride_q[d];
		assign step[d] = step_q[d];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				extent_q[d] <= nsag_pkg::EXTENT_W'(1);
				stride_q[d] <= '0;
				rewind_q[d] <= '0;
				suffix_q[d] <= '0;
				step_q[d]   <= '0;
			end else begin
				if (cfg_we && cfg_index == IDX_W'(d))
					extent_q[d] <= cfg_wdata[nsag_pkg::EXTENT_W-1:0];
				if (cfg_we && cfg_index == IDX_W'(NUM_DIMS + d))
					stride_q[d] <= $signed(cfg_wdata[nsag_pkg::STRIDE_W-1:0]);
				rewind_q[d] <= ADDR_BITS'(prod[d]);
				if (d == NUM_DIMS - 1)
					suffix_q[d] <= '0;
				else
					suffix_q[d] <= suffix_q[(d + 1) % NUM_DIMS] + rewind_q[(d + 1) % NUM_DIMS];
				step_q[d] <= ADDR_BITS'(stride_q[d]) - suffix_q[d];
			end
		end
	end

	// step table valid once the settle counter, reloaded by each write, reaches zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= '0;
		end else if (cfg_we) begin
			settle_q <= SETTLE_W'(NUM_DIMS + 1);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	assign settled = (settle_q == '0);

endmodule

// ----- rtl/nsag_walk.sv -----
// ----------------------------------------------------------------------------
// nsag_walk
// Index counters, current address and output register; one item per cycle while settled and the output is not stalled.
// ----------------------------------------------------------------------------
module nsag_walk #(
	parameter int NUM_DIMS  = 4,
	parameter int ADDR_BITS = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [nsag_pkg::EXTENT_W-1:0] em1 [NUM_DIMS],
	input  logic [ADDR_BITS-1:0]          step [NUM_DIMS],
	input  logic                          settled,
	nsag_cmd_if.sink                      cmd,
	nsag_res_if.source                    res
);

	localparam int DIM_W = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;

	logic [nsag_pkg::EXTENT_W-1:0] idx_q [NUM_DIMS];
	logic [nsag_pkg::EXTENT_W-1:0] idx_d [NUM_DIMS];
	logic [ADDR_BITS-1:0]          addr_q, addr_d;
	logic                          active_q, active_d;
	logic                          out_valid_q;
	logic [ADDR_BITS-1:0]          out_addr_q;
	logic                          out_vres_q;
	logic [NUM_DIMS-1:0]           wrap;
	logic [DIM_W-1:0]              k;
	logic                          found;
	logic                          accept;

	assign cmd.ready = settled && (!out_valid_q || res.ready);
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		k     = '0;
		found = 1'b0;
		for (int d = 0; d < NUM_DIMS; d++) begin
			wrap[d] = (idx_q[d] >= em1[d]);
			if (!wrap[d]) begin
				k     = DIM_W'(d);
				found = 1'b1;
			end
		end

		idx_d    = idx_q;
		addr_d   = addr_q;
		active_d = active_q;
		if (cmd.func == nsag_pkg::FUNC_START) begin
			for (int d = 0; d < NUM_DIMS; d++)
				idx_d[d] = '0;
			addr_d   = cmd.base_address;
			active_d = 1'b1;
		end else if (active_q) begin
			if (found) begin
				for (int d = 0; d < NUM_DIMS; d++) begin
					if (DIM_W'(d) == k)
						idx_d[d] = idx_q[d] + 1'b1;
					else if (DIM_W'(d) > k)
						idx_d[d] = '0;
				end
				addr_d = addr_q + step[k];
			end else begin
				// outermost wrapped: walk over
				for (int d = 0; d < NUM_DIMS; d++)
					idx_d[d] = '0;
				addr_d   = '0;
				active_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DIMS; d++)
				idx_q[d] <= '0;
			addr_q      <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			idx_q       <= idx_d;
			addr_q      <= addr_d;
			active_q    <= active_d;
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_addr_q <= active_d ? addr_d : '0;
			out_vres_q <= active_d;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.address   = out_addr_q;
	assign res.valid_res = out_vres_q;

endmodule

// ----- rtl/nd_strided_address_generator.sv -----
// ----------------------------------------------------------------------------
// nd_strided_address_generator
// Walks an N-dimensional strided view, one byte address per item.
//
//   port   dir     handshake      payload
//   cmd    sink    valid/ready    func, base_address
//   res    source  valid/ready    address, valid_res
//   cfg    in      cfg_we         cfg_index, cfg_wdata
//
// One item per cycle while cmd.ready is high; its result appears in the
// output register in the cycle after acceptance. The counter/address update
// is registered on acceptance. After a register write cmd.ready stays low
// while the step table is rebuilt. Reset gives extents 1, strides 0, walk
// inactive. res.ready low with a result waiting holds it and drops cmd.ready.
// ----------------------------------------------------------------------------
module nd_strided_address_generator #(
	parameter int NUM_DIMS  = 4,
	parameter int ADDR_BITS = 48,
	parameter int CFG_IDX_W = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [CFG_IDX_W-1:0]            cfg_index,
	input  logic [nsag_pkg::CFG_DATA_W-1:0] cfg_wdata,
	nsag_cmd_if.sink                        cmd,
	nsag_res_if.source                      res
);

	logic [nsag_pkg::EXTENT_W-1:0] em1  [NUM_DIMS];
	logic [ADDR_BITS-1:0]          step [NUM_DIMS];
	logic                          settled;

	nsag_cfg #(
		.NUM_DIMS  (NUM_DIMS),
		.ADDR_BITS (ADDR_BITS),
		.IDX_W     (CFG_IDX_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.em1       (em1),
		.step      (step),
		.settled   (settled)
	);

	nsag_walk #(
		.NUM_DIMS  (NUM_DIMS),
		.ADDR_BITS (ADDR_BITS)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.em1     (em1),
		.step    (step),
		.settled (settled),
		.cmd     (cmd),
		.res     (res)
	);

endmodule

// ----- rtl/nsag_checker.sv -----
// ----------------------------------------------------------------------------
// nsag_checker
// Port-level checks of the strided address generator, bound to the top.
// ----------------------------------------------------------------------------
module nsag_checker #(
	parameter int ADDR_BITS = 48
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_we,
	input logic                 cmd_valid,
	input logic                 cmd_ready,
	input nsag_pkg::func_t      cmd_func,
	input logic [ADDR_BITS-1:0] cmd_base_address,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic [ADDR_BITS-1:0] res_address,
	input logic                 res_valid_res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_address)
			&& $stable(res_valid_res))
		else $error("result changed while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_valid_res |-> res_address == '0)
		else $error("ended walk with non-zero address");

	a_start_base: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_func == nsag_pkg::FUNC_START |=>
			res_valid && res_valid_res && res_address == $past(cmd_base_address))
		else $error("start item did not return its base");

	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !cmd_ready)
		else $error("item taken before step table rebuilt");

	a_accept_res: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> res_valid)
		else $error("accepted item gave no result");

endmodule

bind nd_strided_address_generator nsag_checker #(
	.ADDR_BITS (ADDR_BITS)
) u_nsag_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cfg_we           (cfg_we),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.cmd_func         (cmd.func),
	.cmd_base_address (cmd.base_address),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_address      (res.address),
	.res_valid_res    (res.valid_res)
);

// ----- sim/tb_nd_strided_address_generator.sv -----
// ----------------------------------------------------------------------------
// tb_nd_strided_address_generator
// Drives start/advance items into the strided address generator, predicts
// every address from its own copy of the extents, strides and counters, and
// checks each result item in order. It walks directed shapes first (unit
// extents, zero extent, full-scale strides, a shape change mid-walk), then
// random shapes under several idle and stall patterns and one long stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nd_strided_address_generator;

	localparam int NDIM  = 4;
	localparam int ABITS = 48;

	localparam logic [2:0] REG_EXTENT_0 = 3'd0;
	localparam logic [2:0] REG_STRIDE_0 = 3'd4;

	localparam int HOLD_LEN     = 300;
	localparam int PHASE_ITEMS  = 120;
	localparam int RAND_PHASES  = 11;
	localparam int PRESSURE_PH  = 4;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_e;

	typedef struct packed {
		nsag_pkg::func_t  func;
		logic [ABITS-1:0] base;
	} cmd_item_t;

	typedef struct packed {
		logic [ABITS-1:0] address;
		logic             valid_res;
	} addr_due_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [nsag_pkg::CFG_DATA_W-1:0] cfg_wdata;

	nsag_cmd_if #(.ADDR_BITS(ABITS)) cmd_ch ();
	nsag_res_if #(.ADDR_BITS(ABITS)) res_ch ();

	nd_strided_address_generator #(
		.NUM_DIMS (NDIM),
		.ADDR_BITS(ABITS),
		.CFG_IDX_W(3)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd_ch),
		.res      (res_ch)
	);

	// shadow registers and walk state
	logic [nsag_pkg::EXTENT_W-1:0] dim_extent [NDIM];
	logic [nsag_pkg::STRIDE_W-1:0] dim_stride [NDIM];
	logic [nsag_pkg::EXTENT_W-1:0] dim_count  [NDIM];
	logic [ABITS-1:0]    walk_addr;
	logic                walk_on;

	cmd_item_t cmd_pend_q [$];
	addr_due_t addr_due_q [$];

	idle_mode_e idle_mode;
	int items_queued;
	int items_taken;
	int errors;
	logic cmd_took;
	int hold_req;
	int hold_done;
	int hold_left;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic bit roll(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// one step of the walk: counters, address and active flag
	task automatic walk_step(input nsag_pkg::func_t f, input logic [ABITS-1:0] base,
			output addr_due_t due);
		logic [nsag_pkg::EXTENT_W:0] ext;
		logic [ABITS-1:0] stride;
		logic carry;
		if (f == nsag_pkg::FUNC_START) begin
			for (int d = 0; d < NDIM; d++)
				dim_count[d] = '0;
			walk_addr = base;
			walk_on = 1'b1;
		end else if (walk_on) begin
			carry = 1'b1;
			for (int d = NDIM - 1; d >= 0; d--) begin
				if (carry) begin
					ext = (dim_extent[d] == '0) ? 17'd1 : {1'b0, dim_extent[d]};
					stride = {{(ABITS-nsag_pkg::STRIDE_W){dim_stride[d][nsag_pkg::STRIDE_W-1]}},
						dim_stride[d]};
					if ({1'b0, dim_count[d]} + 17'd1 >= ext) begin
						dim_count[d] = '0;
						walk_addr = walk_addr - ABITS'(ext - 17'd1) * stride;
					end else begin
						dim_count[d] = dim_count[d] + 1'b1;
						walk_addr = walk_addr + stride;
						carry = 1'b0;
					end
				end
			end
			if (carry) begin
				for (int d = 0; d < NDIM; d++)
					dim_count[d] = '0;
				walk_addr = '0;
				walk_on = 1'b0;
			end
		end
		due.address = walk_on ? walk_addr : '0;
		due.valid_res = walk_on;
	endtask

	// driver
	always @(negedge clk) begin : drv
		cmd_item_t nxt;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (!cmd_ch.valid || cmd_took) begin
			if (cmd_pend_q.size() != 0 &&
					!roll(idle_mode == IDLE_SENDER ? 78 : idle_mode == IDLE_BOTH ? 18 : 0)) begin
				nxt = cmd_pend_q.pop_front();
				cmd_ch.valid <= 1'b1;
				cmd_ch.func <= nxt.func;
				cmd_ch.base_address <= nxt.base;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_done) begin
			res_ch.ready <= 1'b0;
			hold_left <= HOLD_LEN;
			hold_done <= hold_req;
		end else begin
			res_ch.ready <= !roll(idle_mode == IDLE_RECEIVER ? 78 :
				idle_mode == IDLE_BOTH ? 18 : 0);
		end
	end

	// monitor
	always @(posedge clk) begin : mon
		addr_due_t due;
		if (!arst_n) begin
			cmd_took <= 1'b0;
		end else begin
			cmd_took <= cmd_ch.valid && cmd_ch.ready;
			if (cmd_ch.valid && cmd_ch.ready) begin
				walk_step(cmd_ch.func, cmd_ch.base_address, due);
				addr_due_q.push_back(due);
				items_taken <= items_taken + 1;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (addr_due_q.size() == 0) begin
					$error("unexpected result item: address %h valid_res %b",
						res_ch.address, res_ch.valid_res);
					errors++;
				end else begin
					due = addr_due_q.pop_front();
					if (res_ch.address !== due.address) begin
						$error("address: expected %h, got %h", due.address, res_ch.address);
						errors++;
					end
					if (res_ch.valid_res !== due.valid_res) begin
						$error("valid_res: expected %b, got %b", due.valid_res,
							res_ch.valid_res);
						errors++;
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx,
			input logic [nsag_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		if (idx < REG_STRIDE_0)
			dim_extent[idx[1:0]] = val[nsag_pkg::EXTENT_W-1:0];
		else
			dim_stride[idx[1:0]] = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// index 0 is the outermost dimension
	task automatic load_shape(input logic [NDIM-1:0][nsag_pkg::EXTENT_W-1:0] ext,
			input logic [NDIM-1:0][nsag_pkg::STRIDE_W-1:0] str);
		for (int d = 0; d < NDIM; d++)
			write_reg(REG_EXTENT_0 + 3'(d), nsag_pkg::CFG_DATA_W'(ext[d]));
		for (int d = 0; d < NDIM; d++)
			write_reg(REG_STRIDE_0 + 3'(d), str[d]);
		@(posedge clk);
	endtask

	task automatic queue_item(input nsag_pkg::func_t f, input logic [ABITS-1:0] base);
		cmd_item_t it;
		it.func = f;
		it.base = base;
		cmd_pend_q.push_back(it);
		items_queued++;
	endtask

	task automatic settle();
		while (items_taken != items_queued)
			@(posedge clk);
		while (addr_due_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [ABITS-1:0] rand_base();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return ABITS'($urandom_range(0, 255));
			1: return {ABITS{1'b1}} - ABITS'($urandom_range(0, 255));
			default: return raw[ABITS-1:0];
		endcase
	endfunction

	function automatic logic [nsag_pkg::STRIDE_W-1:0] rand_stride();
		logic [nsag_pkg::STRIDE_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = 32'($urandom_range(0, 256)) - 32'd128;
			2: v = roll(50) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: begin
				v = 32'($urandom_range(1, 16)) * 32'd8;
				if (roll(50))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic logic [nsag_pkg::EXTENT_W-1:0] rand_extent(input bit wide);
		if (!wide)
			return 16'($urandom_range(0, 4));
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1, 2: return 16'd1;
			3, 4, 5: return 16'($urandom_range(2, 4));
			6, 7: return 16'($urandom_range(5, 12));
			8: return 16'hFFFF;
			default: return 16'($urandom_range(1000, 65535));
		endcase
	endfunction

	// element count of the walk, clipped once it is clearly long
	function automatic longint walk_len();
		longint n;
		n = 1;
		for (int d = 0; d < NDIM; d++) begin
			n = n * ((dim_extent[d] == '0) ? 1 : longint'(dim_extent[d]));
			if (n > 1000)
				return n;
		end
		return n;
	endfunction

	// mostly whole or partial walks, some loose items between them
	task automatic fill_walks(input int budget);
		int n;
		int adv;
		longint w;
		n = 0;
		while (n < budget) begin
			if (roll(85)) begin
				queue_item(nsag_pkg::FUNC_START, rand_base());
				n++;
				w = walk_len();
				if (w <= 250 && roll(60))
					adv = int'(w) + $urandom_range(0, 2);
				else
					adv = $urandom_range(0, (w < 60) ? int'(w) : 60);
				repeat (adv) begin
					queue_item(nsag_pkg::FUNC_ADVANCE, rand_base());
					n++;
				end
			end else begin
				queue_item(roll(50) ? nsag_pkg::FUNC_ADVANCE : nsag_pkg::FUNC_START,
					rand_base());
				n++;
			end
		end
	endtask

	initial begin : stim
		logic [NDIM-1:0][nsag_pkg::EXTENT_W-1:0] ext;
		logic [NDIM-1:0][nsag_pkg::STRIDE_W-1:0] str;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = nsag_pkg::FUNC_START;
		cmd_ch.base_address = '0;
		res_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_mode = IDLE_NONE;
		items_queued = 0;
		items_taken = 0;
		errors = 0;
		hold_req = 0;
		hold_done = 0;
		hold_left = 0;
		for (int d = 0; d < NDIM; d++) begin
			dim_extent[d] = 16'd1;
			dim_stride[d] = '0;
			dim_count[d] = '0;
		end
		walk_addr = '0;
		walk_on = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset shape: advance while idle, one-element walk
		queue_item(nsag_pkg::FUNC_ADVANCE, {ABITS{1'b1}});
		queue_item(nsag_pkg::FUNC_START, {ABITS{1'b1}});
		queue_item(nsag_pkg::FUNC_ADVANCE, '0);
		queue_item(nsag_pkg::FUNC_ADVANCE, '0);
		settle();

		// zero extent, full-scale and negative strides, wrap below zero
		ext = {16'd3, 16'd1, 16'd2, 16'd0};
		str = {32'hFFFF_FFFF, 32'h0000_007B, 32'h7FFF_FFFF, 32'h8000_0000};
		load_shape(ext, str);
		queue_item(nsag_pkg::FUNC_START, '0);
		repeat (7) queue_item(nsag_pkg::FUNC_ADVANCE, '0);
		queue_item(nsag_pkg::FUNC_START, {ABITS{1'b1}});
		repeat (2) queue_item(nsag_pkg::FUNC_ADVANCE, {ABITS{1'b1}});
		settle();

		// longest extent, then shrink it while the walk is under way
		ext = {16'hFFFF, 16'd1, 16'd1, 16'd1};
		str = {32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0};
		load_shape(ext, str);
		queue_item(nsag_pkg::FUNC_START, rand_base());
		repeat (5) queue_item(nsag_pkg::FUNC_ADVANCE, '0);
		settle();
		write_reg(REG_EXTENT_0 + 3'd3, 32'd3);
		@(posedge clk);
		repeat (3) queue_item(nsag_pkg::FUNC_ADVANCE, '0);
		settle();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			for (int d = 0; d < NDIM; d++) begin
				ext[d] = rand_extent(ph % 3 == 2);
				str[d] = rand_stride();
			end
			load_shape(ext, str);
			idle_mode = idle_mode_e'(ph % 4);
			fill_walks(PHASE_ITEMS);
			if (ph == PRESSURE_PH) begin
				@(posedge clk);
				hold_req++;
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- nd_strided_address_generator.f -----
rtl/nsag_pkg.sv
rtl/nsag_ifs.sv
rtl/nsag_cfg.sv
rtl/nsag_walk.sv
rtl/nd_strided_address_generator.sv
rtl/nsag_checker.sv
sim/tb_nd_strided_address_generator.sv
